// ----- rtl/tsw_pkg.sv -----
// shared types and constants for the tar stream header walker
package tsw_pkg;

    localparam int SIZE_W = 36;
    localparam int CKS_W = 24;
    localparam int SUM_W = 17;
    localparam int POS_W = 9;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_END = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [POS_W-1:0] POS_SIZE_FIRST = 9'd124;
    localparam logic [POS_W-1:0] POS_SIZE_LAST = 9'd135;
    localparam logic [POS_W-1:0] POS_CKS_FIRST = 9'd148;
    localparam logic [POS_W-1:0] POS_CKS_LAST = 9'd155;
    localparam logic [POS_W-1:0] POS_TYPE = 9'd156;
    localparam logic [POS_W-1:0] POS_BLOCK_LAST = 9'd511;

    localparam logic [7:0] CKS_BLANK = 8'h20;
    localparam logic [7:0] TYPE_DIRECTORY = 8'h35;

    localparam logic [1:0] QUEUE_DEPTH = 2'd2;

    typedef struct packed {
        logic [1:0]        result_kind;
        logic [7:0]        out_byte;
        logic [SIZE_W-1:0] entry_size;
        logic [7:0]        type_flag;
        logic              last_of_file;
    } result_t;

endpackage

// ----- rtl/tsw_front.sv -----
// byte classifier: header parsing, checksum check and data pass-through
module tsw_front import tsw_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] data_byte,
    output logic       push,
    output result_t    push_data
);

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_RUNNING,
        ST_ENDED,
        ST_ERROR
    } status_t;

    typedef struct packed {
        phase_t            phase;
        logic [SIZE_W-1:0] value;
    } octal_t;

    function automatic octal_t octal_step(phase_t ph, logic [SIZE_W-1:0] val,
                                          logic [7:0] b);
        octal_t r;
        logic   digit;
        digit = (b inside {[8'h30:8'h37]});
        r.phase = ph;
        r.value = val;
        case (ph)
            PH_SKIP: begin
                if (digit) begin
                    r.value = {{(SIZE_W-3){1'b0}}, b[2:0]};
                    r.phase = PH_DIGITS;
                end
            end
            PH_DIGITS: begin
                if (digit) begin
                    r.value = {val[SIZE_W-4:0], b[2:0]};
                end else begin
                    r.phase = PH_DONE;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    status_t           status_reg, status_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              zero_reg, zero_next;
    logic [CKS_W-1:0]  cks_reg, cks_next;
    phase_t            cks_ph_reg, cks_ph_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    phase_t            size_ph_reg, size_ph_next;
    logic [7:0]        type_reg, type_next;
    logic              data_mode_reg, data_mode_next;
    logic [SIZE_W-1:0] remain_reg, remain_next;

    octal_t            cks_oct, size_oct;
    logic [SIZE_W-1:0] size_final;
    logic              in_cks, in_size;

    always_comb begin
        status_next    = status_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        zero_next      = zero_reg;
        cks_next       = cks_reg;
        cks_ph_next    = cks_ph_reg;
        size_next      = size_reg;
        size_ph_next   = size_ph_reg;
        type_next      = type_reg;
        data_mode_next = data_mode_reg;
        remain_next    = remain_reg;
        push           = 1'b0;
        push_data      = '0;
        size_final     = '0;
        in_cks         = (pos_reg inside {[POS_CKS_FIRST:POS_CKS_LAST]});
        in_size        = (pos_reg inside {[POS_SIZE_FIRST:POS_SIZE_LAST]});
        cks_oct        = '0;
        size_oct       = '0;

        if (step && status_reg == ST_RUNNING) begin
            pos_next = pos_reg + 1'b1;
            if (data_mode_reg) begin
                if (remain_reg != '0) begin
                    push                   = 1'b1;
                    push_data.result_kind  = KIND_DATA;
                    push_data.out_byte     = data_byte;
                    push_data.entry_size   = size_reg;
                    push_data.type_flag    = type_reg;
                    push_data.last_of_file = (remain_reg == {{(SIZE_W-1){1'b0}}, 1'b1});
                    remain_next            = remain_reg - 1'b1;
                end
                if (pos_reg == POS_BLOCK_LAST && remain_next == '0) begin
                    data_mode_next = 1'b0;
                end
            end else begin
                // start of a header block
                if (pos_reg == '0) begin
                    sum_next     = '0;
                    zero_next    = 1'b1;
                    cks_next     = '0;
                    cks_ph_next  = PH_SKIP;
                    size_next    = '0;
                    size_ph_next = PH_SKIP;
                end
                cks_oct = octal_step(cks_ph_next, {{(SIZE_W-CKS_W){1'b0}}, cks_next},
                                     data_byte);
                size_oct = octal_step(size_ph_next, size_next, data_byte);
                if (in_cks) begin
                    sum_next    = sum_next + {{(SUM_W-8){1'b0}}, CKS_BLANK};
                    cks_ph_next = cks_oct.phase;
                    cks_next    = cks_oct.value[CKS_W-1:0];
                end else begin
                    sum_next = sum_next + {{(SUM_W-8){1'b0}}, data_byte};
                end
                if (in_size) begin
                    size_ph_next = size_oct.phase;
                    size_next    = size_oct.value;
                end
                if (pos_reg == POS_TYPE) begin
                    type_next = data_byte;
                end
                if (data_byte != 8'd0) begin
                    zero_next = 1'b0;
                end

                if (pos_reg == POS_BLOCK_LAST) begin
                    push = 1'b1;
                    if (zero_next) begin
                        push_data.result_kind = KIND_END;
                        status_next           = ST_ENDED;
                    end else if ({{(CKS_W-SUM_W){1'b0}}, sum_next} != cks_next) begin
                        push_data.result_kind = KIND_ERROR;
                        status_next           = ST_ERROR;
                    end else begin
                        size_final = (type_next == TYPE_DIRECTORY) ? '0 : size_next;
                        size_next  = size_final;
                        push_data.result_kind = KIND_HEADER;
                        push_data.entry_size  = size_final;
                        push_data.type_flag   = type_next;
                        if (size_final != '0) begin
                            data_mode_next = 1'b1;
                            remain_next    = size_final;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg    <= ST_RUNNING;
            pos_reg       <= '0;
            sum_reg       <= '0;
            zero_reg      <= 1'b1;
            cks_reg       <= '0;
            cks_ph_reg    <= PH_SKIP;
            size_reg      <= '0;
            size_ph_reg   <= PH_SKIP;
            type_reg      <= '0;
            data_mode_reg <= 1'b0;
            remain_reg    <= '0;
        end else begin
            status_reg    <= status_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            zero_reg      <= zero_next;
            cks_reg       <= cks_next;
            cks_ph_reg    <= cks_ph_next;
            size_reg      <= size_next;
            size_ph_reg   <= size_ph_next;
            type_reg      <= type_next;
            data_mode_reg <= data_mode_next;
            remain_reg    <= remain_next;
        end
    end

endmodule

// ----- rtl/tsw_queue.sv -----
// two-entry result queue that drives the result channel
module tsw_queue import tsw_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t head
);

    result_t    head_reg, head_next;
    result_t    tail_reg, tail_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != 2'd0);
    assign full    = (count_reg == QUEUE_DEPTH);
    assign head    = head_reg;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        case ({push, pop})
            2'b11: begin
                if (count_reg == 2'd1) begin
                    head_next = push_data;
                end else begin
                    head_next = tail_reg;
                    tail_next = push_data;
                end
            end
            2'b01: begin
                head_next  = tail_reg;
                count_next = count_reg - 2'd1;
            end
            2'b10: begin
                if (count_reg == 2'd0) begin
                    head_next = push_data;
                end else begin
                    tail_next = push_data;
                end
                count_next = count_reg + 2'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

// ----- rtl/tar_stream_header_walker.sv -----
// top level of the tar stream header walker
// Takes one archive byte per cycle in 512-byte blocks. Header blocks are
// summed and parsed as they stream in; the verdict (header accepted, end of
// archive or checksum error) is queued after the last byte of the block, and
// the first size bytes of the following data blocks are queued as data
// transfers, the final one flagged. A result is registered in the queue and leaves
// in the cycle after its byte at the earliest. The classifier keeps up with one
// byte per cycle; s_ready drops only while the two-entry result queue is full,
// so the rate is one byte per cycle whenever the result side takes a transfer
// each cycle. After an end of archive or a checksum error further bytes are
// accepted and dropped until reset.
module tar_stream_header_walker import tsw_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_data_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_result_kind,
    output logic [7:0]        m_out_byte,
    output logic [SIZE_W-1:0] m_entry_size,
    output logic [7:0]        m_type_flag,
    output logic              m_last_of_file
);

    logic    step;
    logic    push;
    logic    full;
    result_t push_data;
    result_t head;

    assign s_ready = !full;
    assign step    = s_valid && s_ready;

    tsw_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .data_byte (s_data_byte),
        .push      (push),
        .push_data (push_data)
    );

    tsw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .head      (head)
    );

    assign m_result_kind  = head.result_kind;
    assign m_out_byte     = head.out_byte;
    assign m_entry_size   = head.entry_size;
    assign m_type_flag    = head.type_flag;
    assign m_last_of_file = head.last_of_file;

    // a result only ever comes from an accepted byte
    a_push_from_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> step)
        else $error("result queued without an input transfer");

    // the walker stops after end of archive or checksum error
    a_stop_after_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && (push_data.result_kind == KIND_END ||
                  push_data.result_kind == KIND_ERROR)) |=> !push)
        else $error("result queued after the walker stopped");

    // the last-byte flag belongs to data transfers only
    a_last_on_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_of_file) |-> (m_result_kind == KIND_DATA))
        else $error("last byte flag on a non-data transfer");

endmodule

// ----- bench/tar_stream_header_walker_test.sv -----
// self-checking testbench for the tar stream header walker
module tar_stream_header_walker_test;
    import tsw_pkg::*;

    localparam int BLOCK_BYTES = 512;
    localparam int SIZE_FIELD_LEN = int'(POS_SIZE_LAST - POS_SIZE_FIRST) + 1;
    localparam int CKS_FIELD_LEN = int'(POS_CKS_LAST - POS_CKS_FIRST) + 1;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int CYCLE_LIMIT = 20_000;
    localparam int ENTRY_LEN_MIN = 24;
    localparam int ENTRY_LEN_MAX = 32;
    localparam int STALL_BYTES = 12;
    localparam int TAIL_BYTES = 26;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_SEVEN = 8'h37;
    localparam logic [7:0] TYPE_REGULAR = 8'h30;

    typedef enum logic [1:0] {PARSE_SKIP, PARSE_DIGITS, PARSE_DONE} octal_phase_e;
    typedef enum logic [1:0] {WALK_RUNNING, WALK_ENDED, WALK_FAILED} walk_state_e;
    typedef enum logic [1:0] {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_e;
    typedef enum logic [1:0] {CHK_GOOD, CHK_BIT_FLIP, CHK_WIDE, CHK_NO_DIGITS} check_e;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [7:0]        s_data_byte;
    logic              m_valid;
    logic              m_ready;
    logic [1:0]        m_result_kind;
    logic [7:0]        m_out_byte;
    logic [SIZE_W-1:0] m_entry_size;
    logic [7:0]        m_type_flag;
    logic              m_last_of_file;

    // walker state as seen by the predictor
    logic [POS_W-1:0]  walk_pos = '0;
    logic [SUM_W-1:0]  hdr_sum = '0;
    logic              hdr_all_zero = 1'b1;
    logic [SIZE_W-1:0] cks_value = '0;
    octal_phase_e      cks_phase = PARSE_SKIP;
    logic [SIZE_W-1:0] size_value = '0;
    octal_phase_e      size_phase = PARSE_SKIP;
    logic [7:0]        type_held = '0;
    logic              in_payload = 1'b0;
    logic [SIZE_W-1:0] payload_left = '0;
    walk_state_e       walk_state = WALK_RUNNING;

    result_t    awaited_results[$];
    logic [7:0] hdr_block [0:BLOCK_BYTES-1];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    bit         sender_idles = 1'b1;
    bit         sink_idles = 1'b1;
    bit         hold_off_req = 1'b0;

    tar_stream_header_walker i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_out_byte     (m_out_byte),
        .m_entry_size   (m_entry_size),
        .m_type_flag    (m_type_flag),
        .m_last_of_file (m_last_of_file)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic void octal_feed(inout octal_phase_e phase, inout logic [SIZE_W-1:0] value,
                                       input logic [7:0] b, input int bits);
        logic is_digit;
        is_digit = (b >= ASCII_ZERO) && (b <= ASCII_SEVEN);
        case (phase)
            PARSE_SKIP: begin
                if (is_digit) begin
                    value = SIZE_W'(b - ASCII_ZERO);
                    phase = PARSE_DIGITS;
                end
            end
            PARSE_DIGITS: begin
                if (is_digit) begin
                    value = ((value << 3) | SIZE_W'(b - ASCII_ZERO)) & ((SIZE_W'(1) << bits) - 1);
                end else begin
                    phase = PARSE_DONE;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_walker_byte(input logic [7:0] b);
        result_t r;
        r = '0;
        if (walk_state != WALK_RUNNING) return;
        if (in_payload) begin
            if (payload_left != 0) begin
                r.result_kind = KIND_DATA;
                r.out_byte = b;
                r.entry_size = size_value;
                r.type_flag = type_held;
                r.last_of_file = (payload_left == 1);
                awaited_results.push_back(r);
                payload_left = payload_left - 1'b1;
            end
            if (walk_pos == POS_BLOCK_LAST && payload_left == 0) in_payload = 1'b0;
        end else begin
            if (walk_pos == 0) begin
                hdr_sum = '0;
                hdr_all_zero = 1'b1;
                cks_value = '0;
                cks_phase = PARSE_SKIP;
                size_value = '0;
                size_phase = PARSE_SKIP;
            end
            if (walk_pos >= POS_CKS_FIRST && walk_pos <= POS_CKS_LAST) begin
                hdr_sum = hdr_sum + SUM_W'(CKS_BLANK);
                octal_feed(cks_phase, cks_value, b, CKS_W);
            end else begin
                hdr_sum = hdr_sum + SUM_W'(b);
            end
            if (walk_pos >= POS_SIZE_FIRST && walk_pos <= POS_SIZE_LAST)
                octal_feed(size_phase, size_value, b, SIZE_W);
            if (walk_pos == POS_TYPE) type_held = b;
            if (b != 0) hdr_all_zero = 1'b0;
            if (walk_pos == POS_BLOCK_LAST) begin
                if (hdr_all_zero) begin
                    r.result_kind = KIND_END;
                    walk_state = WALK_ENDED;
                end else if (SIZE_W'(hdr_sum) != cks_value) begin
                    r.result_kind = KIND_ERROR;
                    walk_state = WALK_FAILED;
                end else begin
                    if (type_held == TYPE_DIRECTORY) size_value = '0;
                    r.result_kind = KIND_HEADER;
                    r.entry_size = size_value;
                    r.type_flag = type_held;
                    if (size_value != 0) begin
                        in_payload = 1'b1;
                        payload_left = size_value;
                    end
                end
                awaited_results.push_back(r);
            end
        end
        walk_pos = walk_pos + 1'b1;
    endfunction

    function automatic void compare_field(input string field, input logic [SIZE_W-1:0] want,
                                          input logic [SIZE_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    // result checker
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual kind %0d byte %0h",
                         $time, m_result_kind, m_out_byte);
                mismatch_count++;
            end else begin
                want = awaited_results.pop_front();
                compare_field("result_kind", SIZE_W'(want.result_kind), SIZE_W'(m_result_kind));
                compare_field("out_byte", SIZE_W'(want.out_byte), SIZE_W'(m_out_byte));
                compare_field("entry_size", want.entry_size, m_entry_size);
                compare_field("type_flag", SIZE_W'(want.type_flag), SIZE_W'(m_type_flag));
                compare_field("last_of_file", SIZE_W'(want.last_of_file),
                              SIZE_W'(m_last_of_file));
            end
        end
    end

    // result side, with random stalls and the long hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else if (sink_idles && $urandom_range(0, 15) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic send_archive_byte(input logic [7:0] value);
        if (sender_idles && $urandom_range(0, 15) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_walker_byte(value);
    endtask

    task automatic send_random_bytes(input int count);
        repeat (count) send_archive_byte(8'($urandom));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (awaited_results.size() != 0);
    endtask

    function automatic void octal_layout(input logic [SIZE_W-1:0] value, input int len,
                                         inout int lead, inout int digits);
        int need;
        need = 0;
        for (logic [SIZE_W-1:0] v = value; v != 0; v = v >> 3) need++;
        if (lead < 0) lead = int'($urandom_range(0, len - need));
        if (digits < 0) digits = int'($urandom_range(need, len - lead));
    endfunction

    // non-octal lead-in, digits, a non-octal stop, then anything
    function automatic void write_octal(input int first, input int len,
                                        input logic [SIZE_W-1:0] value, input int lead,
                                        input int digits);
        logic [7:0] b;
        for (int k = 0; k < len; k++) begin
            b = 8'($urandom_range(0, 247));
            if (digits > 0 && k > lead + digits) hdr_block[first + k] = 8'($urandom);
            else hdr_block[first + k] = (b >= ASCII_ZERO) ? b + 8'd8 : b;
        end
        for (int k = 0; k < digits; k++)
            hdr_block[first + lead + k] = ASCII_ZERO + 8'(value[3 * (digits - 1 - k) +: 3]);
    endfunction

    task automatic send_block();
        for (int k = 0; k < BLOCK_BYTES; k++) send_archive_byte(hdr_block[k]);
    endtask

    task automatic send_header(input fill_e fill, input logic [SIZE_W-1:0] entry_len,
                               input int size_lead, input int size_digits,
                               input logic [7:0] type_byte, input check_e check,
                               input int cks_lead, input int cks_digits);
        int total;
        int lead;
        int digits;
        logic [SIZE_W-1:0] cks_text;
        for (int k = 0; k < BLOCK_BYTES; k++) begin
            case (fill)
                FILL_ZERO: hdr_block[k] = 8'h00;
                FILL_ONES: hdr_block[k] = 8'hFF;
                default:   hdr_block[k] = 8'($urandom);
            endcase
        end
        lead = size_lead;
        digits = size_digits;
        octal_layout(entry_len, SIZE_FIELD_LEN, lead, digits);
        write_octal(int'(POS_SIZE_FIRST), SIZE_FIELD_LEN, entry_len, lead, digits);
        hdr_block[POS_TYPE] = type_byte;
        total = CKS_FIELD_LEN * CKS_BLANK;
        for (int k = 0; k < BLOCK_BYTES; k++)
            if (k < POS_CKS_FIRST || k > POS_CKS_LAST) total += hdr_block[k];
        case (check)
            CHK_BIT_FLIP:  cks_text = SIZE_W'(total) ^ (SIZE_W'(1) << $urandom_range(0, SUM_W - 1));
            CHK_WIDE:      cks_text = SIZE_W'(total) + (SIZE_W'(1) << SUM_W);
            CHK_NO_DIGITS: cks_text = '0;
            default:       cks_text = SIZE_W'(total);
        endcase
        lead = cks_lead;
        digits = (check == CHK_NO_DIGITS) ? 0 : cks_digits;
        octal_layout(cks_text, CKS_FIELD_LEN, lead, digits);
        write_octal(int'(POS_CKS_FIRST), CKS_FIELD_LEN, cks_text, lead, digits);
        send_block();
    endtask

    task automatic check_header_fields();
        logic [SIZE_W-1:0] entry_len;
        entry_len = SIZE_W'($urandom_range(ENTRY_LEN_MIN, ENTRY_LEN_MAX));
        // lead-in before the size digits, junk after the stop byte
        send_header(FILL_RANDOM, entry_len, 3, -1, TYPE_REGULAR, CHK_GOOD, -1, -1);
    endtask

    task automatic check_result_backpressure();
        sender_idles = 1'b0;
        hold_off_req = 1'b1;
        send_random_bytes(STALL_BYTES);
        sender_idles = 1'b1;
    endtask

    task automatic check_sender_pause();
        drain_results();
    endtask

    // last data byte of the entry, then padding with no result
    task automatic check_entry_tail();
        send_random_bytes(TAIL_BYTES);
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data_byte = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        check_header_fields();
        check_result_backpressure();
        check_sender_pause();
        sender_idles = 1'b0;
        sink_idles = 1'b0;
        check_entry_tail();
        s_valid <= 1'b0;
        do @(posedge aclk); while (awaited_results.size() != 0);
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
